[hw/rtl/lavm_pkg.sv]
`default_nettype none
package lavm_pkg;

    typedef logic signed [31:0] word_t;
    typedef logic signed [63:0] wide_t;
    typedef logic [2:0][31:0]   vec3_t;

    // Data that rides along the normalizer next to the vector being normalized.
    typedef struct packed {
        vec3_t eye;
        vec3_t wup;
        vec3_t fw;
        logic  ok;
    } side_t;

    typedef struct packed {
        word_t ax;
        word_t ay;
        word_t az;
        word_t tr;
    } row_t;

    typedef struct packed {
        row_t rt;
        row_t up;
        row_t fw;
        logic ok;
    } frame_t;

    typedef struct packed {
        logic [63:0] s;
        logic [63:0] res;
    } sqrt_st_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] low;
        logic [31:0] q;
    } div_st_t;

    localparam int SQRT_STAGES = 16;   // two root bits per stage
    localparam int DIV_STAGES  = 16;   // two quotient bits per stage
    localparam int SQRT_TOP    = 62;

    localparam logic [5:0]  NORM_MSB = 6'd30;
    localparam logic [63:0] RND30    = 64'd1 << 29;

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;

    function automatic logic [63:0] sqrt_bit(input int idx);
        return 64'd1 << (SQRT_TOP - 2 * idx);
    endfunction

    // One step of the digit-by-digit integer square root.
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t st, input logic [63:0] b);
        sqrt_st_t    o;
        logic [63:0] t;
        o = st;
        t = st.res + b;
        if (st.s >= t)
        begin
            o.s   = st.s - t;
            o.res = (st.res >> 1) + b;
        end
        else
        begin
            o.res = st.res >> 1;
        end
        return o;
    endfunction

    // One step of restoring division, quotient MSB first.
    function automatic div_st_t div_step(input div_st_t st, input logic [31:0] len);
        div_st_t     o;
        logic [32:0] r;
        logic        qb;
        r     = {st.rem[31:0], st.low[31]};
        o.low = {st.low[30:0], 1'b0};
        qb    = 1'b0;
        if (r >= {1'b0, len})
        begin
            r  = r - {1'b0, len};
            qb = 1'b1;
        end
        o.rem = r;
        o.q   = {st.q[30:0], qb};
        return o;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lavm_req_if.sv]
`default_nettype none
interface lavm_req_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] world_up_x;
    logic signed [31:0] world_up_y;
    logic signed [31:0] world_up_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               world_up_x, world_up_y, world_up_z,
        input  ready
    );
    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               world_up_x, world_up_y, world_up_z,
        output ready
    );
endinterface
`default_nettype wire

[hw/rtl/lavm_rsp_if.sv]
`default_nettype none
interface lavm_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         row_index;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] translation;
    logic               last_row;
    logic               degenerate;

    modport source (
        output valid, row_index, axis_x, axis_y, axis_z, translation, last_row, degenerate,
        input  ready
    );
    modport sink (
        input  valid, row_index, axis_x, axis_y, axis_z, translation, last_row, degenerate,
        output ready
    );
endinterface
`default_nettype wire

[hw/rtl/lavm_norm.sv]
`default_nettype none
// Pipelined 3-vector normalizer: block shift, sum of squares, root, divide.
module lavm_norm
    import lavm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire wide_t in_v [3],
    input  wire side_t in_side,
    output logic       out_valid,
    output vec3_t      out_q,
    output logic       out_nz,
    output side_t      out_side
);

    // stage 1: magnitudes
    logic        v1_reg;
    logic [62:0] mag1_reg [3];
    logic [62:0] mag1_next [3];
    logic [2:0]  neg1_reg;
    logic [62:0] or1_reg;
    logic [62:0] or1_next;
    side_t       side1_reg;

    // stage 2: per-byte leading one
    logic        v2_reg;
    logic [62:0] mag2_reg [3];
    logic [2:0]  neg2_reg;
    logic [7:0]  bnz2_reg;
    logic [7:0]  bnz2_next;
    logic [2:0]  bmsb2_reg [8];
    logic [2:0]  bmsb2_next [8];
    side_t       side2_reg;

    // stage 3: word leading one
    logic        v3_reg;
    logic [62:0] mag3_reg [3];
    logic [2:0]  neg3_reg;
    logic [5:0]  msb3_reg;
    logic [5:0]  msb3_next;
    logic        nz3_reg;
    side_t       side3_reg;

    // stage 4: block shift
    logic        v4_reg;
    logic [30:0] m4_reg [3];
    logic [30:0] m4_next [3];
    logic [2:0]  neg4_reg;
    logic        nz4_reg;
    side_t       side4_reg;

    // stage 5: squares
    logic        v5_reg;
    logic [61:0] sq5_reg [3];
    logic [61:0] sq5_next [3];
    logic [30:0] m5_reg [3];
    logic [2:0]  neg5_reg;
    logic        nz5_reg;
    side_t       side5_reg;

    // root stages, index 0 holds the sum
    logic [SQRT_STAGES:0] sv_reg;
    sqrt_st_t             sst_reg  [SQRT_STAGES+1];
    logic [30:0]          sm_reg   [SQRT_STAGES+1][3];
    logic [2:0]           sneg_reg [SQRT_STAGES+1];
    logic                 snz_reg  [SQRT_STAGES+1];
    side_t                sside_reg [SQRT_STAGES+1];

    // divide stages, index 0 holds the set-up
    logic [DIV_STAGES:0] dv_reg;
    div_st_t             dst_reg   [DIV_STAGES+1][3];
    div_st_t             dst_next  [3];
    logic [31:0]         dlen_reg  [DIV_STAGES+1];
    logic [2:0]          dneg_reg  [DIV_STAGES+1];
    logic                dnz_reg   [DIV_STAGES+1];
    side_t               dside_reg [DIV_STAGES+1];

    logic        vo_reg;
    vec3_t       q_reg;
    vec3_t       q_next;
    logic        nzo_reg;
    side_t       sideo_reg;

    logic [63:0] or64;
    logic [61:0] num [3];
    logic [5:0]  rs;
    logic [5:0]  ls;

    always_comb
    begin
        or1_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag1_next[i] = in_v[i][63] ? 63'(-in_v[i]) : in_v[i][62:0];
            or1_next     = or1_next | mag1_next[i];
        end
    end

    always_comb
    begin
        or64 = {1'b0, or1_reg};
        for (int g = 0; g < 8; g++)
        begin
            bnz2_next[g]  = |or64[8*g +: 8];
            bmsb2_next[g] = '0;
            for (int b = 0; b < 8; b++)
            begin
                if (or64[8*g + b])
                begin
                    bmsb2_next[g] = 3'(b);
                end
            end
        end
    end

    always_comb
    begin
        msb3_next = '0;
        for (int g = 0; g < 8; g++)
        begin
            if (bnz2_reg[g])
            begin
                msb3_next = {3'(g), bmsb2_reg[g]};
            end
        end
    end

    // largest magnitude lands in [2^30, 2^31)
    always_comb
    begin
        rs = '0;
        ls = '0;
        if (msb3_reg > NORM_MSB)
        begin
            rs = msb3_reg - NORM_MSB;
        end
        else
        begin
            ls = NORM_MSB - msb3_reg;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (msb3_reg > NORM_MSB)
            begin
                m4_next[i] = 31'(mag3_reg[i] >> rs);
            end
            else
            begin
                m4_next[i] = 31'(mag3_reg[i] << ls);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq5_next[i] = m4_reg[i] * m4_reg[i];
        end
    end

    // rounded quotient: (m * 2^30 + len/2) / len
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i] = 62'({sm_reg[SQRT_STAGES][i], 30'b0})
                   + 62'(sst_reg[SQRT_STAGES].res[31:1]);
            dst_next[i].rem = 33'(num[i][61:32]);
            dst_next[i].low = num[i][31:0];
            dst_next[i].q   = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!dnz_reg[DIV_STAGES])
            begin
                q_next[i] = '0;
            end
            else if (dneg_reg[DIV_STAGES][i])
            begin
                q_next[i] = -dst_reg[DIV_STAGES][i].q;
            end
            else
            begin
                q_next[i] = dst_reg[DIV_STAGES][i].q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            sv_reg <= '0;
            dv_reg <= '0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            sv_reg <= {sv_reg[SQRT_STAGES-1:0], v5_reg};
            dv_reg <= {dv_reg[DIV_STAGES-1:0], sv_reg[SQRT_STAGES]};
            vo_reg <= dv_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= mag1_next[i];
                neg1_reg[i] <= in_v[i][63];
            end
            or1_reg   <= or1_next;
            side1_reg <= in_side;

            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            bnz2_reg  <= bnz2_next;
            bmsb2_reg <= bmsb2_next;
            side2_reg <= side1_reg;

            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            msb3_reg  <= msb3_next;
            nz3_reg   <= |bnz2_reg;
            side3_reg <= side2_reg;

            m4_reg    <= m4_next;
            neg4_reg  <= neg3_reg;
            nz4_reg   <= nz3_reg;
            side4_reg <= side3_reg;

            sq5_reg   <= sq5_next;
            m5_reg    <= m4_reg;
            neg5_reg  <= neg4_reg;
            nz5_reg   <= nz4_reg;
            side5_reg <= side4_reg;

            sst_reg[0].s   <= 64'(sq5_reg[0]) + 64'(sq5_reg[1]) + 64'(sq5_reg[2]);
            sst_reg[0].res <= '0;
            sm_reg[0]      <= m5_reg;
            sneg_reg[0]    <= neg5_reg;
            snz_reg[0]     <= nz5_reg;
            sside_reg[0]   <= side5_reg;
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                sst_reg[k+1]   <= sqrt_step(sqrt_step(sst_reg[k], sqrt_bit(2 * k)),
                                            sqrt_bit(2 * k + 1));
                sm_reg[k+1]    <= sm_reg[k];
                sneg_reg[k+1]  <= sneg_reg[k];
                snz_reg[k+1]   <= snz_reg[k];
                sside_reg[k+1] <= sside_reg[k];
            end

            dst_reg[0]   <= dst_next;
            dlen_reg[0]  <= sst_reg[SQRT_STAGES].res[31:0];
            dneg_reg[0]  <= sneg_reg[SQRT_STAGES];
            dnz_reg[0]   <= snz_reg[SQRT_STAGES];
            dside_reg[0] <= sside_reg[SQRT_STAGES];
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dst_reg[k+1][i] <= div_step(div_step(dst_reg[k][i], dlen_reg[k]),
                                                dlen_reg[k]);
                end
                dlen_reg[k+1]  <= dlen_reg[k];
                dneg_reg[k+1]  <= dneg_reg[k];
                dnz_reg[k+1]   <= dnz_reg[k];
                dside_reg[k+1] <= dside_reg[k];
            end

            q_reg     <= q_next;
            nzo_reg   <= dnz_reg[DIV_STAGES];
            sideo_reg <= dside_reg[DIV_STAGES];
        end
    end

    assign out_valid = vo_reg;
    assign out_q     = q_reg;
    assign out_nz    = nzo_reg;
    assign out_side  = sideo_reg;

endmodule
`default_nettype wire

[hw/rtl/lavm_row_ser.sv]
`default_nettype none
// Holds one finished frame and sends its rows right, up, forward.
module lavm_row_ser
    import lavm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire frame_t in_frame,
    output logic        load,
    lavm_rsp_if.source  result
);

    logic       valid_reg;
    logic [1:0] row_reg;
    frame_t     frame_reg;
    row_t       sel;

    assign load = !valid_reg || (row_reg == ROW_FWD && result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            row_reg   <= ROW_RIGHT;
        end
        else if (in_valid && load)
        begin
            valid_reg <= 1'b1;
            row_reg   <= ROW_RIGHT;
        end
        else if (valid_reg && result.ready)
        begin
            if (row_reg == ROW_FWD)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                row_reg <= row_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && load)
        begin
            frame_reg <= in_frame;
        end
    end

    always_comb
    begin
        case (row_reg)
            ROW_RIGHT: sel = frame_reg.rt;
            ROW_UP:    sel = frame_reg.up;
            default:   sel = frame_reg.fw;
        endcase
        result.valid       = valid_reg;
        result.row_index   = row_reg;
        result.axis_x      = frame_reg.ok ? sel.ax : '0;
        result.axis_y      = frame_reg.ok ? sel.ay : '0;
        result.axis_z      = frame_reg.ok ? sel.az : '0;
        result.translation = frame_reg.ok ? sel.tr : '0;
        result.last_row    = (row_reg == ROW_FWD);
        result.degenerate  = !frame_reg.ok;
    end

endmodule
`default_nettype wire

[hw/rtl/look_at_view_matrix_core.sv]
// Path: a request's right row comes out after the input register, both normalizers,
//   cross product, up stages and serializer; up and forward follow as rows are taken.
// Throughput: bounded by the single result port, which sends three rows per
//   request; the pipeline itself takes one request per cycle unless it is held.
// Reset: rst_n is asynchronous, active low, and clears all valid bits and the
//   row counter; data registers are not reset.
`default_nettype none
module look_at_view_matrix_core
    import lavm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lavm_req_if.sink   request,
    lavm_rsp_if.source result
);

    // Whole pipeline moves together; it only holds when its last stage is
    // full and the row serializer cannot take that frame.
    logic en;
    logic ser_load;

    // ---------------------------------------------------------------- input
    logic  t0_v_reg;
    vec3_t t0_eye_reg;
    vec3_t t0_tgt_reg;
    vec3_t t0_wup_reg;

    // --------------------------------------------- forward normalizer
    wide_t n1_in [3];
    side_t n1_side_in;
    logic  n1_valid;
    vec3_t n1_q;
    logic  n1_nz;
    side_t n1_side;

    // --------------------------------------------- cross(world_up, forward)
    logic  c1_v_reg;
    wide_t c1_p_reg [6];
    side_t c1_side_reg;
    logic  c2_v_reg;
    wide_t c2_cr_reg [3];
    side_t c2_side_reg;

    // --------------------------------------------- right normalizer
    logic  n2_valid;
    vec3_t n2_q;
    logic  n2_nz;
    side_t n2_side;

    // --------------------------------------------- up axis, translations
    logic  u1_v_reg;
    wide_t u1_pu_reg [6];
    wide_t u1_per_reg [3];
    wide_t u1_pef_reg [3];
    vec3_t u1_eye_reg;
    vec3_t u1_rt_reg;
    vec3_t u1_fw_reg;
    logic  u1_ok_reg;

    logic  u2_v_reg;
    wide_t u2_upraw_reg [3];
    wide_t u2_dot_r_reg;
    wide_t u2_dot_f_reg;
    vec3_t u2_eye_reg;
    vec3_t u2_rt_reg;
    vec3_t u2_fw_reg;
    logic  u2_ok_reg;

    logic  u3_v_reg;
    vec3_t u3_up_reg;
    word_t u3_tr_r_reg;
    word_t u3_tr_f_reg;
    vec3_t u3_eye_reg;
    vec3_t u3_rt_reg;
    vec3_t u3_fw_reg;
    logic  u3_ok_reg;

    logic  u4_v_reg;
    wide_t u4_peu_reg [3];
    vec3_t u4_up_reg;
    word_t u4_tr_r_reg;
    word_t u4_tr_f_reg;
    vec3_t u4_rt_reg;
    vec3_t u4_fw_reg;
    logic  u4_ok_reg;

    logic  u5_v_reg;
    wide_t u5_dot_u_reg;
    vec3_t u5_up_reg;
    word_t u5_tr_r_reg;
    word_t u5_tr_f_reg;
    vec3_t u5_rt_reg;
    vec3_t u5_fw_reg;
    logic  u5_ok_reg;

    logic   u6_v_reg;
    frame_t u6_frame_reg;

    // Shift right by 30, rounding half away from zero.
    function automatic logic signed [34:0] shr30_round(input wide_t v);
        logic [63:0] u;
        logic [34:0] r;
        u = v[63] ? 64'(-v) : 64'(v);
        r = 35'((u + RND30) >> 30);
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    // Clamp to +-1.0 in Q2.30.
    function automatic word_t clamp_unit(input logic signed [34:0] v);
        if (v > 35'sd1073741824)
        begin
            return 32'sd1073741824;
        end
        if (v < -35'sd1073741824)
        begin
            return -32'sd1073741824;
        end
        return word_t'(v[31:0]);
    endfunction

    // -round(dot >> 30), saturated to Q16.16.
    function automatic word_t trans_sat(input wide_t d);
        logic signed [34:0] sr;
        logic signed [35:0] t;
        sr = shr30_round(d);
        t  = -{sr[34], sr};
        if (t > 36'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (t < -36'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return word_t'(t[31:0]);
    endfunction

    assign en            = !u6_v_reg || ser_load;
    assign request.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_v_reg <= 1'b0;
            c1_v_reg <= 1'b0;
            c2_v_reg <= 1'b0;
            u1_v_reg <= 1'b0;
            u2_v_reg <= 1'b0;
            u3_v_reg <= 1'b0;
            u4_v_reg <= 1'b0;
            u5_v_reg <= 1'b0;
            u6_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t0_v_reg <= request.valid;
            c1_v_reg <= n1_valid;
            c2_v_reg <= c1_v_reg;
            u1_v_reg <= n2_valid;
            u2_v_reg <= u1_v_reg;
            u3_v_reg <= u2_v_reg;
            u4_v_reg <= u3_v_reg;
            u5_v_reg <= u4_v_reg;
            u6_v_reg <= u5_v_reg;
        end
    end

    // eye - target, exact; feeds the first normalizer
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1_in[i] = wide_t'($signed(t0_eye_reg[i])) - wide_t'($signed(t0_tgt_reg[i]));
        end
        n1_side_in.eye = t0_eye_reg;
        n1_side_in.wup = t0_wup_reg;
        n1_side_in.fw  = '0;
        n1_side_in.ok  = 1'b0;
    end

    lavm_norm u_norm_fw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t0_v_reg),
        .in_v      (n1_in),
        .in_side   (n1_side_in),
        .out_valid (n1_valid),
        .out_q     (n1_q),
        .out_nz    (n1_nz),
        .out_side  (n1_side)
    );

    lavm_norm u_norm_rt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c2_v_reg),
        .in_v      (c2_cr_reg),
        .in_side   (c2_side_reg),
        .out_valid (n2_valid),
        .out_q     (n2_q),
        .out_nz    (n2_nz),
        .out_side  (n2_side)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_eye_reg <= {request.eye_z, request.eye_y, request.eye_x};
            t0_tgt_reg <= {request.target_z, request.target_y, request.target_x};
            t0_wup_reg <= {request.world_up_z, request.world_up_y, request.world_up_x};

            // world_up (Q16.16) x forward (Q2.30) -> Q18.46
            c1_p_reg[0] <= $signed(n1_side.wup[1]) * $signed(n1_q[2]);
            c1_p_reg[1] <= $signed(n1_side.wup[2]) * $signed(n1_q[1]);
            c1_p_reg[2] <= $signed(n1_side.wup[2]) * $signed(n1_q[0]);
            c1_p_reg[3] <= $signed(n1_side.wup[0]) * $signed(n1_q[2]);
            c1_p_reg[4] <= $signed(n1_side.wup[0]) * $signed(n1_q[1]);
            c1_p_reg[5] <= $signed(n1_side.wup[1]) * $signed(n1_q[0]);
            c1_side_reg.eye <= n1_side.eye;
            c1_side_reg.wup <= n1_side.wup;
            c1_side_reg.fw  <= n1_q;
            c1_side_reg.ok  <= n1_nz;

            c2_cr_reg[0] <= c1_p_reg[0] - c1_p_reg[1];
            c2_cr_reg[1] <= c1_p_reg[2] - c1_p_reg[3];
            c2_cr_reg[2] <= c1_p_reg[4] - c1_p_reg[5];
            c2_side_reg  <= c1_side_reg;

            // forward x right -> Q4.60, and eye dots for right and forward
            u1_pu_reg[0] <= $signed(n2_side.fw[1]) * $signed(n2_q[2]);
            u1_pu_reg[1] <= $signed(n2_side.fw[2]) * $signed(n2_q[1]);
            u1_pu_reg[2] <= $signed(n2_side.fw[2]) * $signed(n2_q[0]);
            u1_pu_reg[3] <= $signed(n2_side.fw[0]) * $signed(n2_q[2]);
            u1_pu_reg[4] <= $signed(n2_side.fw[0]) * $signed(n2_q[1]);
            u1_pu_reg[5] <= $signed(n2_side.fw[1]) * $signed(n2_q[0]);
            for (int i = 0; i < 3; i++)
            begin
                u1_per_reg[i] <= $signed(n2_side.eye[i]) * $signed(n2_q[i]);
                u1_pef_reg[i] <= $signed(n2_side.eye[i]) * $signed(n2_side.fw[i]);
            end
            u1_eye_reg <= n2_side.eye;
            u1_rt_reg  <= n2_q;
            u1_fw_reg  <= n2_side.fw;
            u1_ok_reg  <= n2_side.ok && n2_nz;

            u2_upraw_reg[0] <= u1_pu_reg[0] - u1_pu_reg[1];
            u2_upraw_reg[1] <= u1_pu_reg[2] - u1_pu_reg[3];
            u2_upraw_reg[2] <= u1_pu_reg[4] - u1_pu_reg[5];
            u2_dot_r_reg    <= u1_per_reg[0] + u1_per_reg[1] + u1_per_reg[2];
            u2_dot_f_reg    <= u1_pef_reg[0] + u1_pef_reg[1] + u1_pef_reg[2];
            u2_eye_reg      <= u1_eye_reg;
            u2_rt_reg       <= u1_rt_reg;
            u2_fw_reg       <= u1_fw_reg;
            u2_ok_reg       <= u1_ok_reg;

            for (int i = 0; i < 3; i++)
            begin
                u3_up_reg[i] <= clamp_unit(shr30_round(u2_upraw_reg[i]));
            end
            u3_tr_r_reg <= trans_sat(u2_dot_r_reg);
            u3_tr_f_reg <= trans_sat(u2_dot_f_reg);
            u3_eye_reg  <= u2_eye_reg;
            u3_rt_reg   <= u2_rt_reg;
            u3_fw_reg   <= u2_fw_reg;
            u3_ok_reg   <= u2_ok_reg;

            // up is only known now, so its dot trails by three stages
            for (int i = 0; i < 3; i++)
            begin
                u4_peu_reg[i] <= $signed(u3_eye_reg[i]) * $signed(u3_up_reg[i]);
            end
            u4_up_reg   <= u3_up_reg;
            u4_tr_r_reg <= u3_tr_r_reg;
            u4_tr_f_reg <= u3_tr_f_reg;
            u4_rt_reg   <= u3_rt_reg;
            u4_fw_reg   <= u3_fw_reg;
            u4_ok_reg   <= u3_ok_reg;

            u5_dot_u_reg <= u4_peu_reg[0] + u4_peu_reg[1] + u4_peu_reg[2];
            u5_up_reg    <= u4_up_reg;
            u5_tr_r_reg  <= u4_tr_r_reg;
            u5_tr_f_reg  <= u4_tr_f_reg;
            u5_rt_reg    <= u4_rt_reg;
            u5_fw_reg    <= u4_fw_reg;
            u5_ok_reg    <= u4_ok_reg;

            u6_frame_reg.rt.ax <= $signed(u5_rt_reg[0]);
            u6_frame_reg.rt.ay <= $signed(u5_rt_reg[1]);
            u6_frame_reg.rt.az <= $signed(u5_rt_reg[2]);
            u6_frame_reg.rt.tr <= u5_tr_r_reg;
            u6_frame_reg.up.ax <= $signed(u5_up_reg[0]);
            u6_frame_reg.up.ay <= $signed(u5_up_reg[1]);
            u6_frame_reg.up.az <= $signed(u5_up_reg[2]);
            u6_frame_reg.up.tr <= trans_sat(u5_dot_u_reg);
            u6_frame_reg.fw.ax <= $signed(u5_fw_reg[0]);
            u6_frame_reg.fw.ay <= $signed(u5_fw_reg[1]);
            u6_frame_reg.fw.az <= $signed(u5_fw_reg[2]);
            u6_frame_reg.fw.tr <= u5_tr_f_reg;
            u6_frame_reg.ok    <= u5_ok_reg;
        end
    end

    // Output buffer: frees the pipeline while rows drain.
    lavm_row_ser u_row_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (u6_v_reg),
        .in_frame (u6_frame_reg),
        .load     (ser_load),
        .result   (result)
    );

endmodule
`default_nettype wire

[hw/rtl/lavm_checker.sv]
`default_nettype none
module lavm_checker
    import lavm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  row_index,
    input wire logic [31:0] axis_x,
    input wire logic [31:0] axis_y,
    input wire logic [31:0] axis_z,
    input wire logic [31:0] translation,
    input wire logic        last_row,
    input wire logic        degenerate
);

    // last_row marks the forward row and nothing else
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_row == (row_index == ROW_FWD)))
        else $error("last_row does not match row_index");

    // rows of one frame come in order
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_row |=>
            out_valid && (row_index == $past(row_index) + 2'd1))
        else $error("row sequence broken");

    // a new frame starts on the right row
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_row ##1 out_valid |-> row_index == ROW_RIGHT)
        else $error("frame does not start at right row");

    // degenerate flag is one value for the whole frame
    a_degen_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_row |=> degenerate == $past(degenerate))
        else $error("degenerate changed within a frame");

    // degenerate rows carry zeros
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |->
            axis_x == '0 && axis_y == '0 && axis_z == '0 && translation == '0)
        else $error("degenerate row is not zero");

endmodule

bind look_at_view_matrix_core lavm_checker u_lavm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .row_index   (result.row_index),
    .axis_x      (result.axis_x),
    .axis_y      (result.axis_y),
    .axis_z      (result.axis_z),
    .translation (result.translation),
    .last_row    (result.last_row),
    .degenerate  (result.degenerate)
);
`default_nettype wire

[test/look_at_view_matrix_core_tb.sv]
`default_nettype none
module look_at_view_matrix_core_tb;
    import lavm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run ceiling: 459 requests, three rows each, with random gaps and one long
    // hold-off; the limit leaves a wide margin over what the run needs.
    localparam int CYCLE_LIMIT = 200000;
    // Pipeline depth of the core, padded.
    localparam int DRAIN_CYCLES = 150;
    // Length of the long result hold-off.
    localparam int HOLD_CYCLES = 400;

    typedef longint lvec_t [3];

    // One row as the core should emit it.
    typedef struct {
        logic [1:0]  row;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] tr;
        logic        last;
        logic        degen;
    } view_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lavm_req_if request();
    lavm_rsp_if result();

    look_at_view_matrix_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request.sink),
        .result  (result.source)
    );

    always #5 clk = ~clk;

    view_row_t pending_rows[$];   // rows predicted, oldest first
    int        errors        = 0;
    int        rows_checked  = 0;
    int        requests_sent = 0;
    int        degen_sent    = 0;
    int        cycles        = 0;

    // Flow control knobs shared between the stimulus and the result sink.
    bit        steady_flow = 1'b0;  // no random idling on either side
    bit        holding     = 1'b0;  // result sink refuses while set
    event      hold_go;             // starts one counted hold-off

    // ------------------------------------------------------------------
    // Fixed-point view matrix predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Shift right by 30, rounding half away from zero.
    function automatic longint round_shr30(input longint v);
        logic [63:0] r;
        r = (magnitude(v) + (64'd1 << 29)) >> 30;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b    = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= root + b)
            begin
                s    = s - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // Unit vector in Q2.30; returns 0 for a zero vector.
    function automatic bit unit_vector(input lvec_t v, output lvec_t q);
        logic [63:0] m [3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] r;
        int          msb;
        mx  = 0;
        sum = 0;
        msb = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = magnitude(v[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            q = '{0, 0, 0};
            return 1'b0;
        end
        for (int b = 0; b < 64; b++)
            if (mx[b])
                msb = b;
        for (int i = 0; i < 3; i++)
        begin
            if (msb > 30)
                m[i] = m[i] >> (msb - 30);
            else
                m[i] = m[i] << (30 - msb);
            sum = sum + m[i] * m[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            r    = ((m[i] << 30) + (len >> 1)) / len;
            q[i] = (v[i] < 0) ? -longint'(r) : longint'(r);
        end
        return 1'b1;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > 64'sd1073741824)
            return 64'sd1073741824;
        if (v < -64'sd1073741824)
            return -64'sd1073741824;
        return v;
    endfunction

    // -dot(eye, axis) in Q16.16, saturated.
    function automatic logic [31:0] eye_offset(input lvec_t eye, input lvec_t ax);
        longint t;
        t = -round_shr30(eye[0] * ax[0] + eye[1] * ax[1] + eye[2] * ax[2]);
        if (t > 64'sd2147483647)
            t = 64'sd2147483647;
        if (t < -64'sd2147483648)
            t = -64'sd2147483648;
        return t[31:0];
    endfunction

    // Predict the three rows for one request and queue them.
    task automatic predict_view_rows(input lvec_t eye, input lvec_t tgt, input lvec_t wup);
        lvec_t     d, fw, cr, rt, up;
        lvec_t     axes [3];
        bit        ok;
        view_row_t r;
        for (int i = 0; i < 3; i++)
            d[i] = eye[i] - tgt[i];
        ok    = unit_vector(d, fw);
        cr[0] = wup[1] * fw[2] - wup[2] * fw[1];
        cr[1] = wup[2] * fw[0] - wup[0] * fw[2];
        cr[2] = wup[0] * fw[1] - wup[1] * fw[0];
        ok    = unit_vector(cr, rt) && ok;
        up[0] = clamp_unit(round_shr30(fw[1] * rt[2] - fw[2] * rt[1]));
        up[1] = clamp_unit(round_shr30(fw[2] * rt[0] - fw[0] * rt[2]));
        up[2] = clamp_unit(round_shr30(fw[0] * rt[1] - fw[1] * rt[0]));
        axes[0] = rt;
        axes[1] = up;
        axes[2] = fw;
        for (int k = 0; k < 3; k++)
        begin
            r.row   = (k == 0) ? ROW_RIGHT : (k == 1) ? ROW_UP : ROW_FWD;
            r.ax    = ok ? axes[k][0][31:0] : 32'd0;
            r.ay    = ok ? axes[k][1][31:0] : 32'd0;
            r.az    = ok ? axes[k][2][31:0] : 32'd0;
            r.tr    = ok ? eye_offset(eye, axes[k]) : 32'd0;
            r.last  = (k == 2);
            r.degen = !ok;
            pending_rows.push_back(r);
        end
        if (!ok)
            degen_sent++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: optional random gap, then hold valid until taken.
    // Called right after a rising edge; ready is looked at mid-cycle.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
        lvec_t eye, tgt, wup;
        if (!steady_flow && $urandom_range(99) < 22)
        begin
            request.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        request.valid      <= 1'b1;
        request.eye_x      <= ex;
        request.eye_y      <= ey;
        request.eye_z      <= ez;
        request.target_x   <= tx;
        request.target_y   <= ty;
        request.target_z   <= tz;
        request.world_up_x <= ux;
        request.world_up_y <= uy;
        request.world_up_z <= uz;
        forever
        begin
            @(negedge clk);
            if (request.ready)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        // taken at this edge
        eye = '{longint'($signed(ex)), longint'($signed(ey)), longint'($signed(ez))};
        tgt = '{longint'($signed(tx)), longint'($signed(ty)), longint'($signed(tz))};
        wup = '{longint'($signed(ux)), longint'($signed(uy)), longint'($signed(uz))};
        predict_view_rows(eye, tgt, wup);
        requests_sent++;
    endtask

    // Mixed-scale coordinate: full range, small, or near a unit step.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
            2: return 32'($signed($urandom_range(2 * 65536)) - 65536);
            default: return {{16{$urandom_range(1) == 1}}, 16'($urandom())};
        endcase
    endfunction

    task automatic send_random_request();
        logic [31:0] e [3], t [3], u [3];
        int          pick;
        for (int i = 0; i < 3; i++)
        begin
            e[i] = pick_coord();
            t[i] = pick_coord();
            u[i] = pick_coord();
        end
        pick = $urandom_range(99);
        if (pick < 4)
            t = e;                           // eye on the target
        else if (pick < 8)
            for (int i = 0; i < 3; i++)      // up along the view line
                u[i] = e[i] - t[i];
        else if (pick < 10)
            u = '{0, 0, 0};
        send_request(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, or a counted hold-off when asked.
    // ------------------------------------------------------------------
    always
    begin
        @(hold_go);
        holding <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++)
            @(posedge clk);
        holding <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (holding)
            result.ready <= 1'b0;
        else
            result.ready <= steady_flow || ($urandom_range(99) >= 22);
    end

    // Result checker, sampled mid-cycle where everything is settled.
    always @(negedge clk)
    begin
        view_row_t x;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_rows.size() == 0)
            begin
                $display("%0t: row %0d arrived with nothing expected", $realtime,
                         result.row_index);
                errors++;
            end
            else
            begin
                x = pending_rows.pop_front();
                rows_checked++;
                if (result.row_index !== x.row || result.axis_x !== x.ax ||
                    result.axis_y !== x.ay || result.axis_z !== x.az ||
                    result.translation !== x.tr || result.last_row !== x.last ||
                    result.degenerate !== x.degen)
                begin
                    $display("%0t: mismatch expected row=%0d ax=%h ay=%h az=%h tr=%h last=%b deg=%b",
                             $realtime, x.row, x.ax, x.ay, x.az, x.tr, x.last, x.degen);
                    $display("%0t:          actual   row=%0d ax=%h ay=%h az=%h tr=%h last=%b deg=%b",
                             $realtime, result.row_index, result.axis_x, result.axis_y,
                             result.axis_z, result.translation, result.last_row,
                             result.degenerate);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d rows outstanding", cycles,
                     pending_rows.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MONE = 32'hFFFF_0000;
    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NMAX = 32'h8000_0000;

    // Ordinary cameras plus the extremes of every field.
    task automatic test_directed_cameras();
        send_request(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
        send_request(3 * ONE, 2 * ONE, 7 * ONE, MONE, 0, ONE, 0, ONE, 0);
        send_request(0, 10 * ONE, 0, 0, 0, 0, 0, 0, ONE);
        send_request(PMAX, PMAX, PMAX, NMAX, NMAX, NMAX, 0, ONE, 0);
        send_request(NMAX, NMAX, NMAX, PMAX, PMAX, PMAX, PMAX, NMAX, PMAX);
        send_request(PMAX, 0, NMAX, 0, PMAX, 0, NMAX, NMAX, PMAX);
        send_request(NMAX, PMAX, 1, 1, NMAX, PMAX, 1, 0, 0);         // saturating offsets
        send_request(1, 0, 0, 0, 0, 0, 0, 1, 0);                     // one-LSB vectors
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0,
                     32'hFFFF_FFFF, 0, 1);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'hEDCB_A987, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333);
        send_request(ONE, ONE, ONE, 0, 0, 0, 0, MONE, 0);
    endtask

    // Zero-length forward or right: eye on target, up along forward, zero up.
    task automatic test_degenerate_frames();
        send_request(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0);
        send_request(NMAX, PMAX, NMAX, NMAX, PMAX, NMAX, PMAX, PMAX, PMAX);
        send_request(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(0, 5 * ONE, 0, 0, 0, 0, 0, ONE, 0);
        send_request(0, 5 * ONE, 0, 0, 0, 0, 0, MONE, 0);
        send_request(3 * ONE, 3 * ONE, 0, 0, 0, 0, 7 * ONE, 7 * ONE, 0);
        send_request(0, 0, 4 * ONE, 0, 0, 0, 0, 0, 0);
        send_request(PMAX, 0, 0, NMAX, 0, 0, NMAX, 0, 0);
    endtask

    task automatic test_random_frames(input int count);
        repeat (count)
            send_random_request();
    endtask

    // Sink holds off for a long stretch while requests keep coming, so the
    // pipeline fills and request.ready must drop.
    task automatic test_result_backpressure();
        steady_flow = 1'b1;
        -> hold_go;
        repeat (60)
            send_random_request();
        steady_flow = 1'b0;
    endtask

    // Long stretch with no idling on either side at full rate.
    task automatic test_steady_stream();
        steady_flow = 1'b1;
        repeat (60)
            send_random_request();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        request.valid      = 1'b0;
        request.eye_x      = '0;
        request.eye_y      = '0;
        request.eye_z      = '0;
        request.target_x   = '0;
        request.target_y   = '0;
        request.target_z   = '0;
        request.world_up_x = '0;
        request.world_up_y = '0;
        request.world_up_z = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cameras();
        test_degenerate_frames();
        test_random_frames(200);
        test_result_backpressure();
        test_steady_stream();
        test_random_frames(120);

        request.valid <= 1'b0;
        wait (pending_rows.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("look-at core: %0d requests (%0d degenerate), %0d rows checked, %0d errors",
                 requests_sent, degen_sent, rows_checked, errors);
        $display("covered field extremes, degenerate frames, random stalls and a long hold-off");
        if (errors == 0 && pending_rows.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
